@@ design/sidec_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII package
// Shared constants, controller states and command/status types.
// ----------------------------------------------------------------------------
package sidec_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int BITS_PER_STEP       = 4;
    localparam int BCD_DIGIT_W         = 4;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_NINE  = 7'd57;
    localparam logic [6:0] ASCII_MINUS = 7'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic scan;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic last_step;
        logic negative;
        logic slot_free;
        logic idx_zero;
    } dp_status_t;

endpackage

@@ design/sidec_if.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII channels
// Valid/ready channel for the integer request and for the character result.
// ----------------------------------------------------------------------------
interface sidec_in_if #(
    parameter int VALUE_WIDTH = sidec_pkg::DEFAULT_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidec_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

@@ design/sidec_dp.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII datapath
// Magnitude shifter, shift-and-add-3 BCD converter, digit pointer and the
// output register of the character channel.
// ----------------------------------------------------------------------------
module sidec_dp #(
    parameter int VALUE_WIDTH = sidec_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sidec_pkg::dp_cmd_t            cmd,
    output sidec_pkg::dp_status_t         status,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [6:0]                    character,
    output logic                          last
);

    localparam int STEP_BITS = sidec_pkg::BITS_PER_STEP;
    localparam int DIG_W     = sidec_pkg::BCD_DIGIT_W;
    localparam int STEPS     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W     = STEPS * STEP_BITS;
    localparam int NDIG      = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_BITS  = NDIG * DIG_W;
    localparam int IDX_W     = $clog2(NDIG);
    localparam int CNT_W     = $clog2(STEPS + 1);

    logic [VALUE_WIDTH-1:0] raw_value;
    logic [VALUE_WIDTH-1:0] abs_value;
    logic [BCD_BITS-1:0]    bcd_work;
    logic [IDX_W-1:0]       lead_idx;
    logic [DIG_W-1:0]       cur_digit;

    logic [PAD_W-1:0]    mag_reg,       mag_next;
    logic [BCD_BITS-1:0] bcd_reg,       bcd_next;
    logic                neg_reg,       neg_next;
    logic [IDX_W-1:0]    idx_reg,       idx_next;
    logic [CNT_W-1:0]    cnt_reg,       cnt_next;
    logic [6:0]          char_reg,      char_next;
    logic                last_reg,      last_next;
    logic                out_valid_reg, out_valid_next;

    assign raw_value = value;
    assign abs_value = raw_value[VALUE_WIDTH-1] ? (~raw_value + 1'b1) : raw_value;

    always_comb
    begin
        bcd_work = bcd_reg;
        for (int b = 0; b < STEP_BITS; b++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_work[d*DIG_W +: DIG_W] >= 4'd5)
                begin
                    bcd_work[d*DIG_W +: DIG_W] = bcd_work[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            bcd_work = {bcd_work[BCD_BITS-2:0], mag_reg[PAD_W-1-b]};
        end
    end

    always_comb
    begin
        lead_idx = '0;
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d*DIG_W +: DIG_W] != 4'd0)
            begin
                lead_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*DIG_W +: DIG_W];

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (cmd.load)
        begin
            mag_next = PAD_W'(abs_value);
            bcd_next = '0;
            neg_next = raw_value[VALUE_WIDTH-1];
            cnt_next = CNT_W'(STEPS);
        end
        if (cmd.step)
        begin
            mag_next = mag_reg << STEP_BITS;
            bcd_next = bcd_work;
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.scan)
        begin
            idx_next = lead_idx;
        end
        if (cmd.emit_sign)
        begin
            char_next      = sidec_pkg::ASCII_MINUS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            char_next      = sidec_pkg::ASCII_ZERO + {3'b000, cur_digit};
            last_next      = (idx_reg == '0);
            idx_next       = idx_reg - 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.last_step = (cnt_reg == CNT_W'(1));
    assign status.negative  = neg_reg;
    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.idx_zero  = (idx_reg == '0);

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

@@ design/sidec_ctrl.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII controller
// Sequences load, conversion steps, leading digit scan and character output.
// ----------------------------------------------------------------------------
module sidec_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sidec_pkg::dp_status_t status,
    output sidec_pkg::dp_cmd_t    cmd
);

    sidec_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sidec_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sidec_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sidec_pkg::ST_CONV;
                end
            end
            sidec_pkg::ST_CONV:
            begin
                if (status.last_step)
                begin
                    state_next = sidec_pkg::ST_SCAN;
                end
            end
            sidec_pkg::ST_SCAN:
            begin
                state_next = status.negative ? sidec_pkg::ST_SIGN : sidec_pkg::ST_DIGIT;
            end
            sidec_pkg::ST_SIGN:
            begin
                if (status.slot_free)
                begin
                    state_next = sidec_pkg::ST_DIGIT;
                end
            end
            sidec_pkg::ST_DIGIT:
            begin
                if (status.slot_free && status.idx_zero)
                begin
                    state_next = sidec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sidec_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            sidec_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sidec_pkg::ST_CONV:
            begin
                cmd.step = 1'b1;
            end
            sidec_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            sidec_pkg::ST_SIGN:
            begin
                cmd.emit_sign = status.slot_free;
            end
            sidec_pkg::ST_DIGIT:
            begin
                cmd.emit_digit = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/signed_integer_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter
// Emits the decimal text of a signed integer, one character per result,
// most significant digit first, with a leading minus for negative values.
// ----------------------------------------------------------------------------
// The first character is shown after the load, the conversion steps, the
// leading digit scan and the output register. A new request is taken only
// once the last character of the previous one has entered the output
// register, as set by the 4-bit-per-cycle BCD converter and the one-character
// output register; characters wait while the output channel is stalled.
// Reset clears the controller and the output valid; no clearing pass is needed.
module signed_integer_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sidec_pkg::DEFAULT_VALUE_WIDTH
) (
    input logic          clk,
    input logic          rst_n,
    sidec_in_if.sink     number,
    sidec_out_if.source  text
);

    sidec_pkg::dp_cmd_t    cmd;
    sidec_pkg::dp_status_t status;

    sidec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sidec_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (number.value),
        .out_ready (text.ready),
        .out_valid (text.valid),
        .character (text.character),
        .last      (text.last)
    );

endmodule

@@ design/sidec_checker.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII checker
// Port-level assertions on the request and character channels.
// ----------------------------------------------------------------------------
module sidec_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] character,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
        else $error("Character result changed while stalled.");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == sidec_pkg::ASCII_MINUS) ||
                      ((character >= sidec_pkg::ASCII_ZERO) &&
                       (character <= sidec_pkg::ASCII_NINE)))
        else $error("Character is neither a minus sign nor a digit.");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (character == sidec_pkg::ASCII_MINUS) |-> !last)
        else $error("Minus sign marked as the final character.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Request accepted while a conversion is in progress.");

endmodule

bind signed_integer_to_decimal_ascii sidec_checker u_sidec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .character (text.character),
    .last      (text.last)
);
